@@ sv/huffman_tree_walk_decoder_core_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define HTWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htwd assertion failed");

// Next-cycle implication.
`define HTWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htwd assertion failed");

`else

`define HTWD_ASSERT_NOW(label, ante, cons)
`define HTWD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/htwd_pkg.sv @@
`timescale 1ns / 1ps

package htwd_pkg;

    localparam int IDX_W = 9;
    localparam int SYM_W = 8;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    localparam int DEFAULT_TABLE_DEPTH = 512;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_MIDCODE = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_t;

endpackage

@@ sv/htwd_in_if.sv @@
`timescale 1ns / 1ps

interface htwd_in_if;
    logic                          valid;
    logic                          ready;
    logic [htwd_pkg::CMD_W-1:0]    cmd;
    logic [htwd_pkg::IDX_W-1:0]    node_index;
    logic [htwd_pkg::IDX_W-1:0]    left_child;
    logic [htwd_pkg::IDX_W-1:0]    right_child;
    logic                          leaf_flag;
    logic [htwd_pkg::SYM_W-1:0]    node_symbol;
    logic                          code_bit;

    modport source (
        output valid, cmd, node_index, left_child, right_child, leaf_flag, node_symbol,
               code_bit,
        input  ready
    );

    modport sink (
        input  valid, cmd, node_index, left_child, right_child, leaf_flag, node_symbol,
               code_bit,
        output ready
    );
endinterface

@@ sv/htwd_out_if.sv @@
`timescale 1ns / 1ps

interface htwd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        symbol_valid;
    logic [htwd_pkg::SYM_W-1:0]  symbol_out;
    logic [htwd_pkg::ST_W-1:0]   status;

    modport source (
        output valid, symbol_valid, symbol_out, status,
        input  ready
    );

    modport sink (
        input  valid, symbol_valid, symbol_out, status,
        output ready
    );
endinterface

@@ sv/huffman_tree_walk_decoder_core.sv @@
// Channel   Dir  Handshake          Payload
// in_chan   in   valid/ready        cmd, node_index, left_child, right_child, leaf_flag,
//                                   node_symbol, code_bit
// out_chan  out  valid/ready        symbol_valid, symbol_out, status
// cfg       in   cfg_we (no ready)  cfg_wdata -> tree_empty
//
// One request per cycle unless out_chan stalls; results pass stage 2 and the output register.
// The node table is one synchronous RAM (registered read); a code bit issues one read of the
// chosen child, whose data is resolved in the next cycle and forwarded straight into the
// address of the following bit.
// Reset clears the walk position, pipeline valids and the root copy; the table is not cleared.
// A stalled output holds one result in the output register and one more in stage 2.
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_core_macros.svh"

module huffman_tree_walk_decoder_core #(
    parameter int TABLE_DEPTH = htwd_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    htwd_in_if.sink           in_chan,
    htwd_out_if.source        out_chan
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Node table and its registered read port
    htwd_pkg::node_t mem [TABLE_DEPTH];
    htwd_pkg::node_t rd_reg;

    // Configuration
    logic tree_empty_reg;

    // Walk state: position plus a cached copy of the current node's children.
    // The root lives in its own copy so a walk at the root needs no table read.
    logic [htwd_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [htwd_pkg::IDX_W-1:0] cur_l_reg, cur_l_next;
    logic [htwd_pkg::IDX_W-1:0] cur_r_reg, cur_r_next;
    htwd_pkg::node_t            root_reg, root_next;

    // Stage 2: one request waiting on the table read or carrying a finished result
    logic                       s2_valid_reg;
    logic                       s2_read_reg;
    logic [htwd_pkg::IDX_W-1:0] s2_addr_reg;
    logic                       s2_sv_reg;
    logic [htwd_pkg::SYM_W-1:0] s2_sym_reg;
    logic [htwd_pkg::ST_W-1:0]  s2_st_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       out_sv_reg;
    logic [htwd_pkg::SYM_W-1:0] out_sym_reg;
    logic [htwd_pkg::ST_W-1:0]  out_st_reg;

    logic in_acc;
    logic s2_adv;

    // Effective walk state once the pending read in stage 2 is folded in
    logic [htwd_pkg::IDX_W-1:0] eff_pos, eff_l, eff_r;
    logic [htwd_pkg::IDX_W-1:0] walk_l, walk_r, next_idx;
    logic                       next_ok;
    logic                       load_ok;

    // Stage 1 decisions
    logic                       mem_we, mem_re;
    htwd_pkg::node_t            mem_wd;
    logic                       s1_read;
    logic                       s1_sv;
    logic [htwd_pkg::SYM_W-1:0] s1_sym;
    logic [htwd_pkg::ST_W-1:0]  s1_st;

    // Stage 2 resolved result
    logic                       s2_sv;
    logic [htwd_pkg::SYM_W-1:0] s2_sym;
    logic [htwd_pkg::ST_W-1:0]  s2_st;

    assign s2_adv        = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = !s2_valid_reg || s2_adv;
    assign in_acc        = in_chan.valid && in_chan.ready;

    // Resolve the pending child read: a leaf sends the walk home, else step into the child
    always_comb
    begin
        eff_pos = pos_reg;
        eff_l   = cur_l_reg;
        eff_r   = cur_r_reg;
        if (s2_read_reg)
        begin
            if (rd_reg.leaf)
            begin
                eff_pos = '0;
            end
            else
            begin
                eff_pos = s2_addr_reg;
                eff_l   = rd_reg.left;
                eff_r   = rd_reg.right;
            end
        end
    end

    // Pick the child for the incoming bit; the root comes from its own copy
    assign walk_l   = (eff_pos == '0) ? root_reg.left  : eff_l;
    assign walk_r   = (eff_pos == '0) ? root_reg.right : eff_r;
    assign next_idx = in_chan.code_bit ? walk_r : walk_l;
    assign next_ok  = (next_idx != '0) && (32'(next_idx) < TABLE_DEPTH);
    assign load_ok  = 32'(in_chan.node_index) < TABLE_DEPTH;

    assign mem_wd = '{left:  in_chan.left_child,
                      right: in_chan.right_child,
                      leaf:  in_chan.leaf_flag,
                      sym:   in_chan.node_symbol};

    always_comb
    begin
        pos_next   = eff_pos;
        cur_l_next = eff_l;
        cur_r_next = eff_r;
        root_next  = root_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        s1_read    = 1'b0;
        s1_sv      = 1'b0;
        s1_sym     = '0;
        s1_st      = htwd_pkg::ST_OK;
        if (in_acc)
        begin
            case (in_chan.cmd)
                htwd_pkg::CMD_LOAD:
                begin
                    if (load_ok)
                    begin
                        mem_we = 1'b1;
                        if (in_chan.node_index == '0)
                        begin
                            root_next = mem_wd;
                        end
                        // Keep the cached current node coherent with the write
                        if ((in_chan.node_index == eff_pos) && (eff_pos != '0))
                        begin
                            cur_l_next = in_chan.left_child;
                            cur_r_next = in_chan.right_child;
                        end
                    end
                end
                htwd_pkg::CMD_BIT:
                begin
                    if (!tree_empty_reg)
                    begin
                        if (root_reg.leaf)
                        begin
                            s1_sv    = 1'b1;
                            s1_sym   = root_reg.sym;
                            pos_next = '0;
                        end
                        else if (!next_ok)
                        begin
                            s1_st    = htwd_pkg::ST_MISSING;
                            pos_next = '0;
                        end
                        else
                        begin
                            // Fetch the child; stage 2 decides leaf or interior
                            s1_read = 1'b1;
                            mem_re  = 1'b1;
                        end
                    end
                end
                htwd_pkg::CMD_END:
                begin
                    if (!tree_empty_reg && (eff_pos != '0))
                    begin
                        s1_st = htwd_pkg::ST_MIDCODE;
                    end
                    pos_next = '0;
                end
                default:
                begin
                    // Drop unknown commands with an all-zero result
                end
            endcase
        end
    end

    // Node table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(in_chan.node_index)] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[AW'(next_idx)];
        end
    end

    // Stage 2 result: a fetched leaf completes the code word
    always_comb
    begin
        if (s2_read_reg)
        begin
            s2_sv  = rd_reg.leaf;
            s2_sym = rd_reg.leaf ? rd_reg.sym : '0;
            s2_st  = htwd_pkg::ST_OK;
        end
        else
        begin
            s2_sv  = s2_sv_reg;
            s2_sym = s2_sym_reg;
            s2_st  = s2_st_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_empty_reg <= 1'b0;
            pos_reg        <= '0;
            root_reg       <= '0;
            s2_valid_reg   <= 1'b0;
            s2_read_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tree_empty_reg <= cfg_wdata;
            end
            pos_reg  <= pos_next;
            root_reg <= root_next;
            if (in_chan.ready)
            begin
                s2_valid_reg <= in_acc;
                s2_read_reg  <= s1_read;
            end
            if (s2_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
        if (in_acc)
        begin
            s2_addr_reg <= next_idx;
            s2_sv_reg   <= s1_sv;
            s2_sym_reg  <= s1_sym;
            s2_st_reg   <= s1_st;
        end
        if (s2_adv && s2_valid_reg)
        begin
            out_sv_reg  <= s2_sv;
            out_sym_reg <= s2_sym;
            out_st_reg  <= s2_st;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.symbol_valid = out_sv_reg;
    assign out_chan.symbol_out   = out_sym_reg;
    assign out_chan.status       = out_st_reg;

    // A pending read always belongs to a live stage 2 request
    `HTWD_ASSERT_NOW(a_read_has_owner, s2_read_reg, s2_valid_reg)
    // An issued read is resolved by stage 2 in the next cycle
    `HTWD_ASSERT_NEXT(a_read_lands, mem_re, s2_read_reg && s2_valid_reg)
    // The table port is never asked to read and write in one cycle
    `HTWD_ASSERT_NOW(a_port_exclusive, mem_we, !mem_re)
    // A blocked output keeps stage 2 occupied
    `HTWD_ASSERT_NEXT(a_s2_holds, s2_valid_reg && !s2_adv, s2_valid_reg)
    // A walk position outside a pending read stays inside the table
    `HTWD_ASSERT_NOW(a_pos_in_table, !s2_read_reg, 32'(pos_reg) < TABLE_DEPTH)

endmodule

@@ tb/huffman_tree_walk_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_core_tb;
    import htwd_pkg::*;

    localparam int TBL_DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int IDLE_PCT     = 24;
    localparam int RANDOM_ITEMS = 2000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;

    // The block ignores the fourth command code; give it a name of its own.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Outcome of stepping from the current node with one code bit.
    typedef enum int {STEP_OK, STEP_MISSING, STEP_UNSAFE} step_kind_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic             code_bit;
    } request_t;

    typedef struct {
        logic             sym_valid;
        logic [SYM_W-1:0] sym;
        logic [ST_W-1:0]  status;
    } decode_out_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    htwd_in_if  in_chan ();
    htwd_out_if out_chan ();

    huffman_tree_walk_decoder_core #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    // Shadow copy of the decoder: node table, which entries hold data, walk
    // position and the empty-tree setting.
    node_t            shadow_table [TBL_DEPTH];
    bit               written      [TBL_DEPTH];
    bit               tree_used    [TBL_DEPTH];
    logic [IDX_W-1:0] walk_pos;
    logic             empty_cfg;

    decode_out_t pending_outputs [$];
    int          error_count;
    int          random_requests;
    int          cycle_count;
    bit          no_idle;

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run; the limit is far above the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_outputs.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stall the result side at random; drop the stalls during the back-to-back stretch.
    always @(negedge clk)
    begin
        out_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Apply one accepted request to the shadow state and return the result it causes.
    function automatic decode_out_t apply_request(request_t r);
        decode_out_t      o;
        node_t            cur;
        logic [IDX_W-1:0] next;
        o.sym_valid = 1'b0;
        o.sym       = '0;
        o.status    = ST_OK;
        case (r.cmd)
            CMD_LOAD:
            begin
                if (r.idx < TBL_DEPTH)
                begin
                    shadow_table[r.idx] = '{left: r.left, right: r.right,
                                            leaf: r.leaf, sym: r.sym};
                    written[r.idx] = 1'b1;
                end
            end
            CMD_BIT:
            begin
                if (!empty_cfg)
                begin
                    if (shadow_table[0].leaf)
                    begin
                        walk_pos    = '0;
                        o.sym_valid = 1'b1;
                        o.sym       = shadow_table[0].sym;
                    end
                    else
                    begin
                        cur  = shadow_table[walk_pos < TBL_DEPTH ? walk_pos : 0];
                        next = r.code_bit ? cur.right : cur.left;
                        if (next == 0 || next >= TBL_DEPTH)
                        begin
                            walk_pos = '0;
                            o.status = ST_MISSING;
                        end
                        else if (shadow_table[next].leaf)
                        begin
                            walk_pos    = '0;
                            o.sym_valid = 1'b1;
                            o.sym       = shadow_table[next].sym;
                        end
                        else
                            walk_pos = next;
                    end
                end
            end
            CMD_END:
            begin
                if (!empty_cfg && walk_pos != 0)
                    o.status = ST_MIDCODE;
                walk_pos = '0;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Classify a code bit so that no request ever reads a node that was never loaded.
    function automatic step_kind_t step_kind(logic b);
        logic [IDX_W-1:0] next;
        if (!written[0])
            return STEP_UNSAFE;
        if (shadow_table[0].leaf)
            return STEP_OK;
        next = b ? shadow_table[walk_pos].right : shadow_table[walk_pos].left;
        if (next == 0 || next >= TBL_DEPTH)
            return STEP_MISSING;
        return written[next] ? STEP_OK : STEP_UNSAFE;
    endfunction

    // Start every request with random content in all fields; callers override what matters.
    function automatic request_t random_request();
        request_t r;
        r.cmd      = CMD_W'($urandom_range(3));
        r.idx      = IDX_W'($urandom_range(TBL_DEPTH - 1));
        r.left     = IDX_W'($urandom_range(TBL_DEPTH - 1));
        r.right    = IDX_W'($urandom_range(TBL_DEPTH - 1));
        r.leaf     = 1'($urandom_range(1));
        r.sym      = SYM_W'($urandom_range(255));
        r.code_bit = 1'($urandom_range(1));
        return r;
    endfunction

    // Present one request, idling at random first, and record its expected result
    // at the edge that accepts it. Valid stays high afterwards until the next falling
    // edge, where the next call either idles or presents the next request.
    task automatic send_request(input request_t r);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_chan.valid = 1'b0;
            @(negedge clk);
        end
        in_chan.valid       = 1'b1;
        in_chan.cmd         = r.cmd;
        in_chan.node_index  = r.idx;
        in_chan.left_child  = r.left;
        in_chan.right_child = r.right;
        in_chan.leaf_flag   = r.leaf;
        in_chan.node_symbol = r.sym;
        in_chan.code_bit    = r.code_bit;
        do
            @(posedge clk);
        while (!in_chan.ready);
        pending_outputs.insert(pending_outputs.size(), apply_request(r));
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] left,
                             input logic [IDX_W-1:0] right, input logic leaf,
                             input logic [SYM_W-1:0] sym);
        request_t r;
        r       = random_request();
        r.cmd   = CMD_LOAD;
        r.idx   = idx;
        r.left  = left;
        r.right = right;
        r.leaf  = leaf;
        r.sym   = sym;
        send_request(r);
    endtask

    task automatic send_bit(input logic b);
        request_t r;
        r          = random_request();
        r.cmd      = CMD_BIT;
        r.code_bit = b;
        send_request(r);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] c);
        request_t r;
        r     = random_request();
        r.cmd = c;
        send_request(r);
    endtask

    // Hold valid low and wait until every expected result has come back.
    task automatic wait_idle();
        @(negedge clk);
        in_chan.valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    // Write the empty-tree setting with the pipeline drained.
    task automatic write_tree_empty(input logic v);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        empty_cfg = v;
    endtask

    // Pick an index not yet used by the tree under construction.
    function automatic logic [IDX_W-1:0] claim_index();
        int i;
        i = $urandom_range(TBL_DEPTH - 1, 1);
        while (tree_used[i])
            i = (i % (TBL_DEPTH - 1)) + 1;
        tree_used[i] = 1'b1;
        return IDX_W'(i);
    endfunction

    // Load a random code tree rooted at node 0, breadth first. A few children are left
    // missing so that the missing-child error shows up inside well-formed streams.
    task automatic load_random_tree(input int interior_budget);
        int               open_nodes [$];
        int               parent;
        logic [IDX_W-1:0] kids [2];
        for (int i = 0; i < TBL_DEPTH; i++)
            tree_used[i] = 1'b0;
        tree_used[0] = 1'b1;
        open_nodes.insert(open_nodes.size(), 0);
        interior_budget--;
        while (open_nodes.size() != 0)
        begin
            parent = open_nodes.pop_front();
            for (int k = 0; k < 2; k++)
            begin
                if ($urandom_range(99) < 6)
                    kids[k] = '0;
                else
                begin
                    kids[k] = claim_index();
                    if (interior_budget > 0 && $urandom_range(99) < 55)
                    begin
                        interior_budget--;
                        open_nodes.insert(open_nodes.size(), int'(kids[k]));
                    end
                    else
                        send_load(kids[k], IDX_W'($urandom_range(TBL_DEPTH - 1)),
                                  IDX_W'($urandom_range(TBL_DEPTH - 1)), 1'b1,
                                  SYM_W'($urandom_range(255)));
                end
            end
            send_load(IDX_W'(parent), kids[0], kids[1], 1'b0, SYM_W'($urandom_range(255)));
        end
    endtask

    // Next request of a decode stream: mostly code bits that follow the loaded tree,
    // with a sprinkle of end markers, ignored commands and stray node loads.
    function automatic request_t next_walk_request();
        request_t    r;
        int unsigned roll;
        step_kind_t  k0;
        step_kind_t  k1;
        r    = random_request();
        roll = $urandom_range(99);
        if (roll < 3)
            r.cmd = CMD_UNUSED;
        else if (roll < 8)
            r.cmd = CMD_END;
        else if (roll < 10)
            r.cmd = CMD_LOAD;
        else if (empty_cfg)
            r.cmd = CMD_BIT;
        else
        begin
            k0 = step_kind(1'b0);
            k1 = step_kind(1'b1);
            r.cmd = CMD_BIT;
            if (k0 == STEP_OK && k1 == STEP_OK)
                ;
            else if (k0 == STEP_OK || k1 == STEP_OK)
            begin
                // Take the branch that continues the code word; rarely take the
                // other one if it only leads to a missing child.
                r.code_bit = (k1 == STEP_OK);
                if ($urandom_range(99) < 8 && (k0 == STEP_MISSING || k1 == STEP_MISSING))
                    r.code_bit = ~r.code_bit;
            end
            else if (k0 == STEP_MISSING || k1 == STEP_MISSING)
                r.code_bit = (k1 == STEP_MISSING);
            else
                r.cmd = CMD_END;
        end
        return r;
    endfunction

    task automatic walk_burst(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_request(next_walk_request());
            random_requests++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] actv);
        if (expv !== actv)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
        end
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        decode_out_t expv;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h", $time,
                         out_chan.symbol_valid, out_chan.symbol_out, out_chan.status);
            end
            else
            begin
                expv = pending_outputs.pop_front();
                check_field("symbol_valid", 8'(expv.sym_valid), 8'(out_chan.symbol_valid));
                check_field("symbol_out", expv.sym, out_chan.symbol_out);
                check_field("status", 8'(expv.status), 8'(out_chan.status));
            end
        end
    end

    // Ignored command, end at the root, and a root that is itself a leaf.
    task automatic test_root_cases();
        send_cmd(CMD_UNUSED);
        send_cmd(CMD_END);
        send_load(9'd0, 9'd511, 9'd0, 1'b1, 8'hFF);
        send_bit(1'b0);
        send_bit(1'b1);
    endtask

    // Small hand-built tree with extreme indices and symbols; cover a missing child,
    // end in mid-code, and an ignored command in the middle of a code word.
    task automatic test_small_tree();
        send_load(9'd0, 9'd1, 9'd511, 1'b0, 8'h00);
        send_load(9'd1, 9'd0, 9'd0, 1'b1, 8'h00);
        send_load(9'd511, 9'd0, 9'd2, 1'b0, 8'hFF);
        send_load(9'd2, 9'd511, 9'd511, 1'b1, 8'hA5);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_cmd(CMD_UNUSED);
        send_bit(1'b1);
        send_bit(1'b1);
        send_cmd(CMD_END);
        send_cmd(CMD_END);
    endtask

    // Empty-tree setting: bits are swallowed, an end in mid-code reports nothing.
    task automatic test_empty_tree();
        send_bit(1'b1);
        write_tree_empty(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_cmd(CMD_END);
        write_tree_empty(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
    endtask

    // Stretch with both sides always ready.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        load_random_tree(20);
        walk_burst(200);
        no_idle = 1'b0;
    endtask

    // Let the sender stop mid-stream until every result has drained, then resume.
    task automatic test_sender_pause();
        load_random_tree(10);
        walk_burst(40);
        wait_idle();
        walk_burst(40);
    endtask

    // Many random trees, each followed by a decode stream; the empty-tree setting
    // changes between phases.
    task automatic test_random_trees();
        while (random_requests < RANDOM_ITEMS)
        begin
            write_tree_empty(1'($urandom_range(99) < 15));
            if ($urandom_range(7) == 0)
                send_load(9'd0, IDX_W'($urandom_range(TBL_DEPTH - 1)),
                          IDX_W'($urandom_range(TBL_DEPTH - 1)), 1'b1,
                          SYM_W'($urandom_range(255)));
            else
                load_random_tree($urandom_range(40, 1));
            walk_burst($urandom_range(200, 60));
        end
        write_tree_empty(1'b0);
    endtask

    initial
    begin
        // Drive every input to a known value while reset is held low.
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        in_chan.valid        = 1'b0;
        in_chan.cmd          = CMD_LOAD;
        in_chan.node_index   = '0;
        in_chan.left_child   = '0;
        in_chan.right_child  = '0;
        in_chan.leaf_flag    = 1'b0;
        in_chan.node_symbol  = '0;
        in_chan.code_bit     = 1'b0;
        walk_pos             = '0;
        empty_cfg            = 1'b0;
        random_requests      = 0;
        no_idle              = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            shadow_table[i] = '0;
            written[i]      = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_root_cases();
        test_small_tree();
        test_empty_tree();
        test_back_to_back();
        test_sender_pause();
        test_random_trees();

        // Drain, then give stray results a chance to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
